### hw/rtl/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// shared types, constants and codes of the variable partition allocator
// ----------------------------------------------------------------------------
package vpa_pkg;

   localparam int SIZE_WIDTH = 16;
   localparam int DEF_MAX_PARTITIONS = 64;
   localparam logic [SIZE_WIDTH-1:0] RESET_MEMORY_SIZE = SIZE_WIDTH'(50);

   localparam logic [1:0] CSR_FIT_POLICY = 2'd0;
   localparam logic [1:0] CSR_MEMORY_SIZE = 2'd1;

   localparam logic [1:0] POLICY_BEST = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   localparam logic CMD_FREE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_FIT    = 3'd1,
      ST_BAD_SIZE  = 3'd2,
      ST_BAD_INDEX = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_INIT, OP_LOAD, OP_RD_SCAN, OP_CHECK, OP_MARK, OP_SPLIT_RD,
      OP_SPLIT_WR, OP_WR_CHOSEN, OP_WR_REM, OP_RD_POS, OP_CAP, OP_WR_MERGE,
      OP_SHIFT_RD, OP_SHIFT_WR, OP_RESULT
   } op_type;

   typedef enum logic [1:0] {
      SEL_SELF, SEL_NEXT, SEL_PREV
   } sel_type;

   typedef struct packed {
      logic                  cmd;
      logic [SIZE_WIDTH-1:0] request_size;
      logic [5:0]            partition_index;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [SIZE_WIDTH-1:0] alloc_address;
      logic [5:0]            alloc_index;
      logic [6:0]            partitions_in_use;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_WIDTH-1:0] start;
      logic [SIZE_WIDTH-1:0] size;
      logic                  busy;
   } entry_type;

   typedef struct packed {
      op_type     op;
      sel_type    sel;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic init_pending;
      logic is_free;
      logic need_zero;
      logic idx_bad;
      logic scan_done;
      logic found;
      logic exact;
      logic full;
      logic split_done;
      logic shift_done;
   } stat_type;

endpackage

### hw/rtl/variable_partition_allocator.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator
// first, best or worst fit allocator over an address-ordered partition table
// ----------------------------------------------------------------------------
// channel   ports                          direction
// req       req_valid/req_ready/req_payload  in   allocate or free beat
// rsp       rsp_valid/rsp_ready/rsp_payload  out  status beat, one per req
// csr       csr_we/csr_index/csr_wdata       in   fit_policy, memory_size
//
// allocate: a read and a check per table entry searched, plus a read and a write per entry moved on a split
// free: reads the entry and its next and previous neighbours, writes the merged entry,
// then a read and a write per entry moved down after a merge
// reset and each memory_size write rebuild the table as one free entry before the next req
// a finished beat waits in the output register while the next req is taken
// ----------------------------------------------------------------------------
module variable_partition_allocator #(
   parameter int MAX_PARTITIONS = vpa_pkg::DEF_MAX_PARTITIONS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  vpa_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output vpa_pkg::rsp_type                rsp_payload,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [vpa_pkg::SIZE_WIDTH-1:0]  csr_wdata
);

   vpa_pkg::cmd_type  cmd;
   vpa_pkg::stat_type st;

   vpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   vpa_dp #(
      .MAX_PARTITIONS (MAX_PARTITIONS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .st          (st),
      .rsp_payload (rsp_payload)
   );

endmodule

### hw/rtl/vpa_dp.sv
// ----------------------------------------------------------------------------
// vpa_dp
// partition table memory, config registers, search and shift datapath
// ----------------------------------------------------------------------------
module vpa_dp #(
   parameter int MAX_PARTITIONS = vpa_pkg::DEF_MAX_PARTITIONS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [vpa_pkg::SIZE_WIDTH-1:0]  csr_wdata,
   input  vpa_pkg::req_type                req_payload,
   input  vpa_pkg::cmd_type                cmd,
   output vpa_pkg::stat_type               st,
   output vpa_pkg::rsp_type                rsp_payload
);

   localparam int SW = vpa_pkg::SIZE_WIDTH;
   localparam int IW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam int CW = $clog2(MAX_PARTITIONS + 1);
   localparam int PW = (CW > 6) ? CW : 6;

   vpa_pkg::entry_type mem [MAX_PARTITIONS];
   vpa_pkg::entry_type rd_data_ff;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   vpa_pkg::entry_type wr_data;

   logic [1:0]    fit_policy_ff, fit_policy_in;
   logic [SW-1:0] memory_size_ff, memory_size_in;
   logic          init_pending_ff, init_pending_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] shift_ff, shift_in;
   logic          found_ff, found_in;
   logic          prev_free_ff, prev_free_in;
   logic          next_free_ff, next_free_in;

   logic          is_free_ff, is_free_in;
   logic          idx_bad_ff, idx_bad_in;
   logic [SW-1:0] need_ff, need_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] chosen_ff, chosen_in;
   logic [SW-1:0] csize_ff, csize_in;
   logic [SW-1:0] cstart_ff, cstart_in;
   logic [SW-1:0] msize_ff, msize_in;
   logic [SW-1:0] mstart_ff, mstart_in;
   vpa_pkg::rsp_type rsp_ff, rsp_in;

   logic          stop_on_first;
   logic          fits;
   logic          better;
   logic          next_ok;
   logic [IW-1:0] prev_addr;
   logic [IW-1:0] next_addr;
   logic [IW-1:0] pos_addr;
   logic [CW-1:0] merge_cnt;
   logic [IW-1:0] base;

   assign stop_on_first = (fit_policy_ff != vpa_pkg::POLICY_BEST)
                       && (fit_policy_ff != vpa_pkg::POLICY_WORST);
   assign fits = !rd_data_ff.busy && (rd_data_ff.size >= need_ff);
   assign better = ((fit_policy_ff == vpa_pkg::POLICY_BEST) && (rd_data_ff.size < csize_ff))
                || ((fit_policy_ff == vpa_pkg::POLICY_WORST) && (rd_data_ff.size > csize_ff));
   assign next_ok = ((CW'(pos_ff) + CW'(1)) < count_ff);
   assign prev_addr = (pos_ff == '0) ? pos_ff : pos_ff - IW'(1);
   assign next_addr = next_ok ? pos_ff + IW'(1) : pos_ff;
   assign merge_cnt = CW'(prev_free_ff) + CW'(next_free_ff);
   assign base = prev_free_ff ? pos_ff - IW'(1) : pos_ff;

   always_comb begin
      case (cmd.sel)
         vpa_pkg::SEL_NEXT: pos_addr = next_addr;
         vpa_pkg::SEL_PREV: pos_addr = prev_addr;
         default:           pos_addr = pos_ff;
      endcase
   end

   // table port selection
   always_comb begin
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      case (cmd.op)
         vpa_pkg::OP_RD_SCAN:  rd_addr = scan_ff[IW-1:0];
         vpa_pkg::OP_SPLIT_RD: rd_addr = IW'(shift_ff - CW'(1));
         vpa_pkg::OP_RD_POS:   rd_addr = pos_addr;
         vpa_pkg::OP_SHIFT_RD: rd_addr = IW'(shift_ff + merge_cnt);
         vpa_pkg::OP_INIT: begin
            wr_en = 1'b1;
            wr_data = '{start: '0, size: memory_size_ff, busy: 1'b0};
         end
         vpa_pkg::OP_MARK: begin
            wr_en = 1'b1;
            wr_addr = chosen_ff;
            wr_data = '{start: cstart_ff, size: csize_ff, busy: 1'b1};
         end
         vpa_pkg::OP_SPLIT_WR: begin
            wr_en = 1'b1;
            wr_addr = IW'(shift_ff);
            wr_data = rd_data_ff;
         end
         vpa_pkg::OP_WR_CHOSEN: begin
            wr_en = 1'b1;
            wr_addr = chosen_ff;
            wr_data = '{start: cstart_ff, size: need_ff, busy: 1'b1};
         end
         vpa_pkg::OP_WR_REM: begin
            wr_en = 1'b1;
            wr_addr = chosen_ff + IW'(1);
            wr_data = '{start: cstart_ff + need_ff, size: csize_ff - need_ff, busy: 1'b0};
         end
         vpa_pkg::OP_WR_MERGE: begin
            wr_en = 1'b1;
            wr_addr = base;
            wr_data = '{start: mstart_ff, size: msize_ff, busy: 1'b0};
         end
         vpa_pkg::OP_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_addr = IW'(shift_ff);
            wr_data = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      fit_policy_in = fit_policy_ff;
      memory_size_in = memory_size_ff;
      init_pending_in = init_pending_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      shift_in = shift_ff;
      found_in = found_ff;
      prev_free_in = prev_free_ff;
      next_free_in = next_free_ff;
      is_free_in = is_free_ff;
      idx_bad_in = idx_bad_ff;
      need_in = need_ff;
      pos_in = pos_ff;
      chosen_in = chosen_ff;
      csize_in = csize_ff;
      cstart_in = cstart_ff;
      msize_in = msize_ff;
      mstart_in = mstart_ff;
      rsp_in = rsp_ff;
      case (cmd.op)
         vpa_pkg::OP_INIT: begin
            init_pending_in = 1'b0;
            count_in = CW'(1);
         end
         vpa_pkg::OP_LOAD: begin
            is_free_in = (req_payload.cmd == vpa_pkg::CMD_FREE);
            need_in = req_payload.request_size;
            pos_in = IW'(req_payload.partition_index);
            idx_bad_in = (PW'(req_payload.partition_index) >= PW'(count_ff));
            scan_in = '0;
            shift_in = count_ff;
            found_in = 1'b0;
            prev_free_in = 1'b0;
            next_free_in = 1'b0;
         end
         vpa_pkg::OP_CHECK: begin
            if (fits && (!found_ff || better)) begin
               found_in = 1'b1;
               chosen_in = scan_ff[IW-1:0];
               csize_in = rd_data_ff.size;
               cstart_in = rd_data_ff.start;
            end
            scan_in = scan_ff + CW'(1);
         end
         vpa_pkg::OP_SPLIT_WR: shift_in = shift_ff - CW'(1);
         vpa_pkg::OP_WR_REM:   count_in = count_ff + CW'(1);
         vpa_pkg::OP_CAP: begin
            case (cmd.sel)
               vpa_pkg::SEL_NEXT: begin
                  if (next_ok && !rd_data_ff.busy) begin
                     next_free_in = 1'b1;
                     msize_in = msize_ff + rd_data_ff.size;
                  end
               end
               vpa_pkg::SEL_PREV: begin
                  if ((pos_ff != '0) && !rd_data_ff.busy) begin
                     prev_free_in = 1'b1;
                     mstart_in = rd_data_ff.start;
                     msize_in = msize_ff + rd_data_ff.size;
                  end
               end
               default: begin
                  mstart_in = rd_data_ff.start;
                  msize_in = rd_data_ff.size;
               end
            endcase
         end
         vpa_pkg::OP_WR_MERGE: begin
            count_in = count_ff - merge_cnt;
            shift_in = CW'(base) + CW'(1);
         end
         vpa_pkg::OP_SHIFT_WR: shift_in = shift_ff + CW'(1);
         vpa_pkg::OP_RESULT: begin
            rsp_in.status = cmd.status;
            rsp_in.partitions_in_use = 7'(count_ff);
            if ((cmd.status == vpa_pkg::ST_OK) && !is_free_ff) begin
               rsp_in.alloc_address = cstart_ff;
               rsp_in.alloc_index = 6'(chosen_ff);
            end else begin
               rsp_in.alloc_address = '0;
               rsp_in.alloc_index = '0;
            end
         end
         default: begin
         end
      endcase
      if (csr_we && (csr_index == vpa_pkg::CSR_FIT_POLICY)) begin
         fit_policy_in = csr_wdata[1:0];
      end
      if (csr_we && (csr_index == vpa_pkg::CSR_MEMORY_SIZE)) begin
         memory_size_in = csr_wdata;
         init_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff <= '0;
         memory_size_ff <= vpa_pkg::RESET_MEMORY_SIZE;
         init_pending_ff <= 1'b1;
         count_ff <= CW'(1);
         scan_ff <= '0;
         shift_ff <= '0;
         found_ff <= 1'b0;
         prev_free_ff <= 1'b0;
         next_free_ff <= 1'b0;
      end else begin
         fit_policy_ff <= fit_policy_in;
         memory_size_ff <= memory_size_in;
         init_pending_ff <= init_pending_in;
         count_ff <= count_in;
         scan_ff <= scan_in;
         shift_ff <= shift_in;
         found_ff <= found_in;
         prev_free_ff <= prev_free_in;
         next_free_ff <= next_free_in;
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff <= is_free_in;
      idx_bad_ff <= idx_bad_in;
      need_ff <= need_in;
      pos_ff <= pos_in;
      chosen_ff <= chosen_in;
      csize_ff <= csize_in;
      cstart_ff <= cstart_in;
      msize_ff <= msize_in;
      mstart_ff <= mstart_in;
      rsp_ff <= rsp_in;
   end

   assign st.init_pending = init_pending_ff;
   assign st.is_free = is_free_ff;
   assign st.need_zero = (need_ff == '0);
   assign st.idx_bad = idx_bad_ff;
   assign st.scan_done = (scan_ff >= count_ff) || (found_ff && stop_on_first);
   assign st.found = found_ff;
   assign st.exact = (csize_ff == need_ff);
   assign st.full = (count_ff >= CW'(MAX_PARTITIONS));
   assign st.split_done = (shift_ff <= CW'(chosen_ff));
   assign st.shift_done = (merge_cnt == '0) || (shift_ff >= count_ff);
   assign rsp_payload = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CW'(MAX_PARTITIONS)))
      else $error("entry count out of range");

   a_split_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == vpa_pkg::OP_WR_REM) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("split did not add an entry");

   a_chosen_valid: assert property (@(posedge clock) disable iff (reset)
      ((cmd.op == vpa_pkg::OP_MARK) || (cmd.op == vpa_pkg::OP_WR_CHOSEN))
      |-> (CW'(chosen_ff) < count_ff))
      else $error("chosen entry beyond table");

endmodule

### hw/rtl/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// vpa_ctrl
// sequencer for search, split, merge and result handoff
// ----------------------------------------------------------------------------
module vpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  vpa_pkg::stat_type  st,
   output vpa_pkg::cmd_type   cmd
);

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_DISPATCH = 14'b00000000000010,
      S_SCAN_RD  = 14'b00000000000100,
      S_SCAN_CHK = 14'b00000000001000,
      S_DECIDE   = 14'b00000000010000,
      S_SPLIT_RD = 14'b00000000100000,
      S_SPLIT_WR = 14'b00000001000000,
      S_WR_REM   = 14'b00000010000000,
      S_FR_RD    = 14'b00000100000000,
      S_FR_CAP   = 14'b00001000000000,
      S_MERGE_WR = 14'b00010000000000,
      S_SHIFT_RD = 14'b00100000000000,
      S_SHIFT_WR = 14'b01000000000000,
      S_DONE     = 14'b10000000000000
   } state_type;

   state_type           state_ff, state_in;
   vpa_pkg::sel_type    sel_ff, sel_in;
   vpa_pkg::status_type status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && !st.init_pending && !csr_we;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op = vpa_pkg::OP_NONE;
      cmd.sel = sel_ff;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (st.init_pending) begin
               cmd.op = vpa_pkg::OP_INIT;
            end else if (req_valid && req_ready) begin
               cmd.op = vpa_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (st.is_free) begin
               if (st.idx_bad) begin
                  status_in = vpa_pkg::ST_BAD_INDEX;
                  state_in = S_DONE;
               end else begin
                  sel_in = vpa_pkg::SEL_SELF;
                  state_in = S_FR_RD;
               end
            end else if (st.need_zero) begin
               status_in = vpa_pkg::ST_BAD_SIZE;
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (st.scan_done) begin
               state_in = S_DECIDE;
            end else begin
               cmd.op = vpa_pkg::OP_RD_SCAN;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            cmd.op = vpa_pkg::OP_CHECK;
            state_in = S_SCAN_RD;
         end
         S_DECIDE: begin
            if (!st.found) begin
               status_in = vpa_pkg::ST_NO_FIT;
               state_in = S_DONE;
            end else if (st.exact) begin
               cmd.op = vpa_pkg::OP_MARK;
               status_in = vpa_pkg::ST_OK;
               state_in = S_DONE;
            end else if (st.full) begin
               status_in = vpa_pkg::ST_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_SPLIT_RD;
            end
         end
         S_SPLIT_RD: begin
            if (st.split_done) begin
               cmd.op = vpa_pkg::OP_WR_CHOSEN;
               state_in = S_WR_REM;
            end else begin
               cmd.op = vpa_pkg::OP_SPLIT_RD;
               state_in = S_SPLIT_WR;
            end
         end
         S_SPLIT_WR: begin
            cmd.op = vpa_pkg::OP_SPLIT_WR;
            state_in = S_SPLIT_RD;
         end
         S_WR_REM: begin
            cmd.op = vpa_pkg::OP_WR_REM;
            status_in = vpa_pkg::ST_OK;
            state_in = S_DONE;
         end
         S_FR_RD: begin
            cmd.op = vpa_pkg::OP_RD_POS;
            state_in = S_FR_CAP;
         end
         S_FR_CAP: begin
            cmd.op = vpa_pkg::OP_CAP;
            case (sel_ff)
               vpa_pkg::SEL_SELF: begin
                  sel_in = vpa_pkg::SEL_NEXT;
                  state_in = S_FR_RD;
               end
               vpa_pkg::SEL_NEXT: begin
                  sel_in = vpa_pkg::SEL_PREV;
                  state_in = S_FR_RD;
               end
               default: state_in = S_MERGE_WR;
            endcase
         end
         S_MERGE_WR: begin
            cmd.op = vpa_pkg::OP_WR_MERGE;
            state_in = S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            if (st.shift_done) begin
               status_in = vpa_pkg::ST_OK;
               state_in = S_DONE;
            end else begin
               cmd.op = vpa_pkg::OP_SHIFT_RD;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.op = vpa_pkg::OP_SHIFT_WR;
            state_in = S_SHIFT_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = vpa_pkg::OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff <= vpa_pkg::SEL_SELF;
         status_ff <= vpa_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         status_ff <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_split_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPLIT_RD) |-> (st.found && !st.full && !st.exact))
      else $error("split entered without room or fit");

   a_merge_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE_WR) |-> (st.is_free && !st.idx_bad))
      else $error("merge on bad free request");

endmodule
